// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands included by touch_median_filter_and_scale.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clock edge outside of reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Check that cond never holds at a rising clock edge outside of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// File: design/tmfs_pkg.sv
// ----------------------------------------------------------------------------
// tmfs_pkg
// Constants for the touch median filter and range map.
// ----------------------------------------------------------------------------
package tmfs_pkg;

	localparam int BURST_LEN      = 12;
	localparam int MEDIAN_RANK    = 6;
	localparam int OUT_FULL_SCALE = 1023;

	localparam int RAW_W = 12;
	localparam int POS_W = 10;
	localparam int CFG_IDX_W = 2;

	// Rank past the end of the burst picks the largest element.
	localparam int RANK_SEL = (MEDIAN_RANK >= BURST_LEN) ? BURST_LEN - 1 : MEDIAN_RANK;

	localparam int IDX_W     = $clog2(BURST_LEN);
	localparam int CNT_W     = $clog2(BURST_LEN + 1);
	localparam int QUO_W     = $clog2(OUT_FULL_SCALE + 1);
	localparam int NUM_W     = RAW_W + QUO_W;
	localparam int DIV_CNT_W = $clog2(QUO_W);

	localparam logic [RAW_W-1:0] RAW_MAX = {RAW_W{1'b1}};

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_X_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_MAX = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MIN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_MAX = 2'd3;

endpackage

// File: design/touch_median_filter_and_scale.sv
// ----------------------------------------------------------------------------
// touch_median_filter_and_scale
// Collects bursts of X/Y ADC pairs, picks the rank median per axis and maps
// it linearly from the configured range onto 0..1023, clamped at both ends.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in       | sink      | in_valid / in_stall | x_sample, y_sample (12 b)
//  out      | source    | out_valid/out_stall | x_pos, y_pos (10 b)
//  cfg      | sink      | cfg_wr_en           | cfg_index (2 b), cfg_data (12 b)
//
// A word is taken every cycle while a burst fills. After the last word of a
// burst the sample memory is swept once per candidate (LOAD, CAND, SCAN, EVAL;
// at most 12 candidates) on its single read port, then a map step, 10
// restoring divide steps and a hand-off, with in_stall held meanwhile and
// longer while the previous result still waits on out_stall.
// A result waiting on out_stall does not block the next burst's collection.
// Reset clears control and sets both ranges to 0..4095; sample memory needs none.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_median_filter_and_scale (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [tmfs_pkg::RAW_W-1:0]    x_sample,
	input  logic [tmfs_pkg::RAW_W-1:0]    y_sample,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [tmfs_pkg::POS_W-1:0]    x_pos,
	output logic [tmfs_pkg::POS_W-1:0]    y_pos,
	input  logic                          cfg_wr_en,
	input  logic [tmfs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tmfs_pkg::RAW_W-1:0]    cfg_data
);
	import tmfs_pkg::*;

	typedef enum logic [6:0] {
		S_COLLECT = 7'b0000001,
		S_LOAD    = 7'b0000010,
		S_CAND    = 7'b0000100,
		S_SCAN    = 7'b0001000,
		S_EVAL    = 7'b0010000,
		S_MAP     = 7'b0100000,
		S_DIV     = 7'b1000000
	} state_t;

	// S_DIV finishes into a result hand-off, tracked by done_q
	state_t state_q;
	logic   done_q;

	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     cand_idx_q;
	logic [CNT_W-1:0]     scan_idx_q;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [1:0]           found_q;
	logic                 out_valid_q;
	logic [POS_W-1:0]     x_pos_q;
	logic [POS_W-1:0]     y_pos_q;

	logic [RAW_W-1:0] lo_q [2];
	logic [RAW_W-1:0] hi_q [2];

	logic [2*RAW_W-1:0] sample_mem [BURST_LEN];
	logic [2*RAW_W-1:0] rdata_q;
	logic [IDX_W-1:0]   rd_addr;

	logic [RAW_W-1:0] cand_q [2];
	logic [RAW_W-1:0] med_q [2];
	logic [CNT_W-1:0] lt_q [2];
	logic [CNT_W-1:0] le_q [2];
	logic [RAW_W-1:0] rem_q [2];
	logic [QUO_W-1:0] quo_q [2];
	logic [RAW_W-1:0] dvs_q [2];
	logic [1:0]       zero_q;
	logic [1:0]       sat_q;

	logic [RAW_W-1:0] rd_raw [2];
	logic [1:0]       hit;
	logic [RAW_W-1:0] diff [2];
	logic [NUM_W-1:0] num [2];
	logic [RAW_W:0]   shifted [2];
	logic [RAW_W:0]   trial [2];
	logic [1:0]       ge;
	logic [QUO_W-1:0] res [2];

	logic in_acc;
	logic out_load;

	assign in_stall  = (state_q != S_COLLECT) || done_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign x_pos     = x_pos_q;
	assign y_pos     = y_pos_q;
	assign out_load  = done_q && (!out_valid_q || !out_stall);

	assign rd_raw[0] = rdata_q[2*RAW_W-1:RAW_W];
	assign rd_raw[1] = rdata_q[RAW_W-1:0];

	always_comb begin
		if (state_q == S_LOAD) begin
			rd_addr = cand_idx_q;
		end else if (scan_idx_q < CNT_W'(BURST_LEN)) begin
			rd_addr = scan_idx_q[IDX_W-1:0];
		end else begin
			rd_addr = '0;
		end
	end

	always_comb begin
		for (int a = 0; a < 2; a++) begin
			hit[a] = !found_q[a] && (lt_q[a] <= CNT_W'(RANK_SEL)) &&
				(le_q[a] > CNT_W'(RANK_SEL));
			diff[a]    = med_q[a] - lo_q[a];
			num[a]     = NUM_W'(diff[a]) * NUM_W'(OUT_FULL_SCALE);
			shifted[a] = {rem_q[a], quo_q[a][QUO_W-1]};
			trial[a]   = shifted[a] - {1'b0, dvs_q[a]};
			ge[a]      = shifted[a] >= {1'b0, dvs_q[a]};
			if (zero_q[a]) begin
				res[a] = '0;
			end else if (sat_q[a]) begin
				res[a] = QUO_W'(OUT_FULL_SCALE);
			end else begin
				res[a] = quo_q[a];
			end
		end
	end

	// Sample memory: one write port for collection, one registered read port
	always_ff @(posedge clk) begin
		rdata_q <= sample_mem[rd_addr];
		if (in_acc) begin
			sample_mem[cnt_q[IDX_W-1:0]] <= {x_sample, y_sample};
		end
	end

	// Median search and divider datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_CAND: begin
				for (int a = 0; a < 2; a++) begin
					cand_q[a] <= rd_raw[a];
					lt_q[a]   <= '0;
					le_q[a]   <= '0;
				end
			end
			S_SCAN: begin
				for (int a = 0; a < 2; a++) begin
					if (rd_raw[a] < cand_q[a]) begin
						lt_q[a] <= lt_q[a] + CNT_W'(1);
					end
					if (rd_raw[a] <= cand_q[a]) begin
						le_q[a] <= le_q[a] + CNT_W'(1);
					end
				end
			end
			S_EVAL: begin
				for (int a = 0; a < 2; a++) begin
					if (hit[a]) begin
						med_q[a] <= cand_q[a];
					end
				end
			end
			S_MAP: begin
				for (int a = 0; a < 2; a++) begin
					zero_q[a] <= (hi_q[a] <= lo_q[a]) || (med_q[a] <= lo_q[a]);
					sat_q[a]  <= med_q[a] >= hi_q[a];
					dvs_q[a]  <= hi_q[a] - lo_q[a];
					rem_q[a]  <= num[a][NUM_W-1:QUO_W];
					quo_q[a]  <= num[a][QUO_W-1:0];
				end
			end
			S_DIV: begin
				if (!done_q) begin
					for (int a = 0; a < 2; a++) begin
						rem_q[a] <= ge[a] ? trial[a][RAW_W-1:0] : shifted[a][RAW_W-1:0];
						quo_q[a] <= {quo_q[a][QUO_W-2:0], ge[a]};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_COLLECT;
			done_q      <= 1'b0;
			cnt_q       <= '0;
			cand_idx_q  <= '0;
			scan_idx_q  <= '0;
			div_cnt_q   <= '0;
			found_q     <= '0;
			out_valid_q <= 1'b0;
			x_pos_q     <= '0;
			y_pos_q     <= '0;
			lo_q[0]     <= '0;
			hi_q[0]     <= RAW_MAX;
			lo_q[1]     <= '0;
			hi_q[1]     <= RAW_MAX;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_X_MIN: lo_q[0] <= cfg_data;
					REG_X_MAX: hi_q[0] <= cfg_data;
					REG_Y_MIN: lo_q[1] <= cfg_data;
					REG_Y_MAX: hi_q[1] <= cfg_data;
					default: begin
					end
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
				x_pos_q     <= POS_W'(res[0]);
				y_pos_q     <= POS_W'(res[1]);
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				S_COLLECT: begin
					if (in_acc) begin
						if (cnt_q == CNT_W'(BURST_LEN - 1)) begin
							cnt_q      <= '0;
							cand_idx_q <= '0;
							found_q    <= '0;
							state_q    <= S_LOAD;
						end else begin
							cnt_q <= cnt_q + CNT_W'(1);
						end
					end
				end
				S_LOAD: begin
					scan_idx_q <= '0;
					state_q    <= S_CAND;
				end
				S_CAND: begin
					scan_idx_q <= CNT_W'(1);
					state_q    <= S_SCAN;
				end
				S_SCAN: begin
					scan_idx_q <= scan_idx_q + CNT_W'(1);
					if (scan_idx_q == CNT_W'(BURST_LEN)) begin
						state_q <= S_EVAL;
					end
				end
				S_EVAL: begin
					found_q <= found_q | hit;
					// Stop once both axes have their median, or after the last candidate
					if ((&(found_q | hit)) || (cand_idx_q == IDX_W'(BURST_LEN - 1))) begin
						state_q <= S_MAP;
					end else begin
						cand_idx_q <= cand_idx_q + IDX_W'(1);
						state_q    <= S_LOAD;
					end
				end
				S_MAP: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					if (done_q) begin
						if (out_load) begin
							done_q  <= 1'b0;
							state_q <= S_COLLECT;
						end
					end else if (div_cnt_q == DIV_CNT_W'(QUO_W - 1)) begin
						done_q <= 1'b1;
					end else begin
						div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
					end
				end
				default: begin
					state_q <= S_COLLECT;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_last_word_starts_search, clk, arst_n,
		in_acc && (cnt_q == CNT_W'(BURST_LEN - 1)) |=> (state_q == S_LOAD) && (cnt_q == '0),
		"last word of a burst did not start the median search")
	`ASSERT_CLK(a_map_has_medians, clk, arst_n,
		(state_q == S_MAP) |-> (found_q == 2'b11),
		"range map entered without a median on both axes")
	`ASSERT_CLK(a_result_from_divider, clk, arst_n,
		$rose(out_valid_q) |-> $past(done_q && (state_q == S_DIV)),
		"result raised without a finished divide")
	`ASSERT_NEVER(a_stall_while_busy, clk, arst_n,
		in_acc && done_q,
		"word taken while a result hand-off is pending")

endmodule

// File: test/touch_median_filter_and_scale_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_median_filter_and_scale_tb
// Feeds bursts of X/Y sample pairs under several range settings and handshake
// loads. Each burst is predicted (rank median per axis, linear map, clamp) or
// listed (directed ones) and compared with the pair that the block returns.
// ----------------------------------------------------------------------------
module touch_median_filter_and_scale_tb;
	import tmfs_pkg::*;

	localparam int PICK_RANK     = (MEDIAN_RANK >= BURST_LEN) ? BURST_LEN - 1 : MEDIAN_RANK;
	localparam int RAW_TOP       = (1 << RAW_W) - 1;
	localparam int RAND_WORDS    = 1226;
	localparam int SETTLE_CYCLES = 240;
	localparam int HOLD_CYCLES   = 600;
	localparam int LIMIT_CYCLES  = 400000;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} pos_pair_t;

	typedef struct packed {
		logic [RAW_W-1:0] x_lo, x_hi, y_lo, y_hi;
		logic [RAW_W-1:0] xa, xb, ya, yb;
		logic [POS_W-1:0] xp, yp;
	} dir_row_t;

	// Even words carry xa/ya, odd words xb/yb; rank 6 of 12 is then the larger one.
	localparam dir_row_t DIR_ROWS [2] = '{
		'{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd100, 12'd4095, 12'd0, 12'd0,
			10'd1023, 10'd0},
		'{12'd2000, 12'd2000, 12'd100, 12'd300, 12'd0, 12'd4095, 12'd50, 12'd4000,
			10'd0, 10'd1023}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [RAW_W-1:0]     x_sample;
	logic [RAW_W-1:0]     y_sample;
	logic                 out_valid;
	logic                 out_stall;
	logic [POS_W-1:0]     x_pos;
	logic [POS_W-1:0]     y_pos;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [RAW_W-1:0]     cfg_data;

	// burst predictor state
	logic [RAW_W-1:0] x_hist [BURST_LEN];
	logic [RAW_W-1:0] y_hist [BURST_LEN];
	int               fill;
	logic [RAW_W-1:0] x_lo, x_hi, y_lo, y_hi;

	pos_pair_t pos_due [$];
	int        fail_count;
	int        pos_checked;
	int        words_sent;
	int        settings_used;
	int        tx_idle_pct;
	int        rx_stall_pct;
	int        hold_asks;
	int        hold_seen;
	int        hold_left;
	int        cycle_count;

	touch_median_filter_and_scale u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.x_sample  (x_sample),
		.y_sample  (y_sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.x_pos     (x_pos),
		.y_pos     (y_pos),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [RAW_W-1:0] burst_median(input bit y_axis);
		logic [RAW_W-1:0] v;
		int lt, le;
		for (int i = 0; i < BURST_LEN; i++) begin
			v = y_axis ? y_hist[i] : x_hist[i];
			lt = 0;
			le = 0;
			for (int j = 0; j < BURST_LEN; j++) begin
				if ((y_axis ? y_hist[j] : x_hist[j]) < v) lt++;
				if ((y_axis ? y_hist[j] : x_hist[j]) <= v) le++;
			end
			if (lt <= PICK_RANK && PICK_RANK < le) return v;
		end
		return '0;
	endfunction

	function automatic logic [POS_W-1:0] scale_pos(input int v, input int lo, input int hi);
		int q;
		if (hi <= lo || v <= lo) return '0;
		q = (v - lo) * OUT_FULL_SCALE / (hi - lo);
		if (q > OUT_FULL_SCALE) q = OUT_FULL_SCALE;
		return q[POS_W-1:0];
	endfunction

	function automatic bit absorb_pair(input logic [RAW_W-1:0] xs, input logic [RAW_W-1:0] ys,
			output pos_pair_t res);
		x_hist[fill] = xs;
		y_hist[fill] = ys;
		fill++;
		res = '0;
		if (fill < BURST_LEN) return 1'b0;
		fill = 0;
		res.x = scale_pos(int'(burst_median(1'b0)), int'(x_lo), int'(x_hi));
		res.y = scale_pos(int'(burst_median(1'b1)), int'(y_lo), int'(y_hi));
		return 1'b1;
	endfunction

	function automatic logic [RAW_W-1:0] draw_sample(input int ctr, input int spread,
			input int style);
		int v;
		case (style)
			0: v = int'($urandom_range(RAW_TOP));
			1: v = $urandom_range(1) ? RAW_TOP : 0;
			default: begin
				// occasional outlier inside a clustered burst
				if ($urandom_range(11) == 0) v = int'($urandom_range(RAW_TOP));
				else v = int'($urandom_range(2 * spread)) + ctr - spread;
			end
		endcase
		if (v < 0) v = 0;
		if (v > RAW_TOP) v = RAW_TOP;
		return v[RAW_W-1:0];
	endfunction

	task automatic send_word(input logic [RAW_W-1:0] xs, input logic [RAW_W-1:0] ys,
			input bit typed_given, input pos_pair_t typed);
		pos_pair_t res;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		x_sample <= xs;
		y_sample <= ys;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		words_sent++;
		if (absorb_pair(xs, ys, res)) pos_due.push_back(typed_given ? typed : res);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RAW_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_X_MIN: x_lo = val;
			REG_X_MAX: x_hi = val;
			REG_Y_MIN: y_lo = val;
			REG_Y_MAX: y_hi = val;
			default: ;
		endcase
	endtask

	task automatic set_ranges(input logic [RAW_W-1:0] xl, input logic [RAW_W-1:0] xh,
			input logic [RAW_W-1:0] yl, input logic [RAW_W-1:0] yh);
		write_reg(REG_X_MIN, xl);
		write_reg(REG_X_MAX, xh);
		write_reg(REG_Y_MIN, yl);
		write_reg(REG_Y_MAX, yh);
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	// Drop valid, wait for every position, then let a full burst computation pass.
	task automatic drain_and_settle();
		in_valid <= 1'b0;
		while (pos_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// receiver: stall pattern, long hold on request, position check
	initial begin
		out_stall = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				if (out_valid && !out_stall) begin
					if (pos_due.size() == 0) begin
						$error("x_pos/y_pos %0d/%0d arrived with nothing expected", x_pos, y_pos);
						fail_count++;
					end else begin
						pos_checked++;
						if (x_pos !== pos_due[0].x) begin
							$error("x_pos: expected %0d, got %0d", pos_due[0].x, x_pos);
							fail_count++;
						end
						if (y_pos !== pos_due[0].y) begin
							$error("y_pos: expected %0d, got %0d", pos_due[0].y, y_pos);
							fail_count++;
						end
						void'(pos_due.pop_front());
					end
				end
				if (hold_seen != hold_asks) begin
					hold_seen = hold_asks;
					hold_left = HOLD_CYCLES;
				end
				if (hold_left > 0) begin
					hold_left--;
					out_stall <= 1'b1;
				end else begin
					out_stall <= ($urandom_range(99) < rx_stall_pct);
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	initial begin
		int n, phase, rand_sent, lo_c, hi_c;
		int x_ctr, y_ctr, x_spr, y_spr, x_sty, y_sty;
		logic [RAW_W-1:0] nxl, nxh, nyl, nyh;
		arst_n = 1'b0;
		in_valid = 1'b0;
		x_sample = '0;
		y_sample = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_X_MIN;
		cfg_data = '0;
		fill = 0;
		x_lo = '0;
		x_hi = RAW_W'(RAW_TOP);
		y_lo = '0;
		y_hi = RAW_W'(RAW_TOP);
		fail_count = 0;
		pos_checked = 0;
		words_sent = 0;
		settings_used = 0;
		tx_idle_pct = 0;
		rx_stall_pct = 0;
		hold_asks = 0;
		x_ctr = 0;
		y_ctr = 0;
		x_spr = 0;
		y_spr = 0;
		x_sty = 0;
		y_sty = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed bursts: full range, empty range, clamp at both ends
		for (int r = 0; r < 2; r++) begin
			drain_and_settle();
			set_ranges(DIR_ROWS[r].x_lo, DIR_ROWS[r].x_hi, DIR_ROWS[r].y_lo, DIR_ROWS[r].y_hi);
			for (int k = 0; k < BURST_LEN; k++)
				send_word(k[0] ? DIR_ROWS[r].xb : DIR_ROWS[r].xa,
					k[0] ? DIR_ROWS[r].yb : DIR_ROWS[r].ya,
					1'b1, {DIR_ROWS[r].xp, DIR_ROWS[r].yp});
		end

		// random phases; a phase may end mid-burst so the next setting lands inside it
		phase = 0;
		rand_sent = 0;
		while (rand_sent < RAND_WORDS) begin
			drain_and_settle();
			case (phase)
				0: begin nxl = 0;    nxh = 4095; nyl = 0;    nyh = 4095; end
				1: begin nxl = 4095; nxh = 4095; nyl = 0;    nyh = 0;    end
				2: begin nxl = 0;    nxh = 1;    nyl = 4094; nyh = 4095; end
				3: begin nxl = 3000; nxh = 1000; nyl = 512;  nyh = 3583; end
				default: begin
					nxl = RAW_W'($urandom_range(RAW_TOP));
					nxh = ($urandom_range(5) == 0) ? nxl : RAW_W'($urandom_range(RAW_TOP));
					nyl = RAW_W'($urandom_range(RAW_TOP));
					nyh = ($urandom_range(5) == 0) ? nyl : RAW_W'($urandom_range(RAW_TOP));
				end
			endcase
			set_ranges(nxl, nxh, nyl, nyh);
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 46; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 46; end
				default: begin tx_idle_pct = 24; rx_stall_pct = 24; end
			endcase
			// hold the output while words keep coming so the block backs up
			if (phase == 0) hold_asks++;
			n = $urandom_range(200, 100);
			for (int k = 0; k < n && rand_sent < RAND_WORDS; k++) begin
				if (fill == 0) begin
					x_sty = $urandom_range(19);
					y_sty = $urandom_range(19);
					lo_c = ((x_lo < x_hi) ? int'(x_lo) : int'(x_hi)) - 80;
					hi_c = ((x_lo < x_hi) ? int'(x_hi) : int'(x_lo)) + 80;
					if (lo_c < 0) lo_c = 0;
					if (hi_c > RAW_TOP) hi_c = RAW_TOP;
					x_ctr = int'($urandom_range(hi_c, lo_c));
					x_spr = int'($urandom_range(150));
					lo_c = ((y_lo < y_hi) ? int'(y_lo) : int'(y_hi)) - 80;
					hi_c = ((y_lo < y_hi) ? int'(y_hi) : int'(y_lo)) + 80;
					if (lo_c < 0) lo_c = 0;
					if (hi_c > RAW_TOP) hi_c = RAW_TOP;
					y_ctr = int'($urandom_range(hi_c, lo_c));
					y_spr = int'($urandom_range(150));
				end
				send_word(draw_sample(x_ctr, x_spr, (x_sty < 3) ? 0 : (x_sty < 5) ? 1 : 2),
					draw_sample(y_ctr, y_spr, (y_sty < 3) ? 0 : (y_sty < 5) ? 1 : 2),
					1'b0, '0);
				rand_sent++;
			end
			phase++;
		end

		drain_and_settle();
		$display("summary: %0d words sent, %0d position pairs checked", words_sent, pos_checked);
		$display("summary: %0d range settings incl. empty, inverted and saturating ranges",
			settings_used);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// File: touch_median_filter_and_scale.f
+incdir+design
design/tmfs_pkg.sv
design/touch_median_filter_and_scale.sv
test/touch_median_filter_and_scale_tb.sv
